### hw/rtl/assert_macros.svh
// Assertion macros shared by the scheduler RTL.
// Depends on nothing; the bodies vanish when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define MLFQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define MLFQ_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define MLFQ_ASSERT(label, clk, rst, prop, msg)
`define MLFQ_NEVER(label, clk, rst, expr, msg)
`endif
`endif

### hw/rtl/mlfq_pkg.sv
// Package for the multilevel feedback queue scheduler: sizes, types and codes.
// Used by every module of the block; depends on nothing.
package mlfq_pkg;

   localparam int LEVELS     = 7;
   localparam int LAST_LEVEL = 6;
   localparam int DEPTH      = 8;
   localparam int BURST_BITS = 16;
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int LEVEL_W    = 3;
   localparam int REQ_BURST_W = 16;
   localparam int SERVE_W    = 2;
   localparam int TALLY_W    = 2;

   typedef logic [BURST_BITS-1:0] burst_type;
   typedef logic [CNT_W-1:0]      count_type;
   typedef logic [LEVEL_W-1:0]    level_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SERVE,
      ST_REPLY
   } state_type;

   localparam logic CMD_ENQUEUE = 1'b0;
   localparam logic CMD_PASS    = 1'b1;

   localparam level_type LEVEL_LAST = LEVEL_W'(LAST_LEVEL);

   typedef struct packed {
      logic      pop;
      logic      push;
      logic      set_head;
      burst_type data;
   } level_ctl_type;

   function automatic logic [SERVE_W-1:0] serve_limit(input level_type lv);
      logic [SERVE_W-1:0] lim;
      unique case (lv)
         3'd0, 3'd1: lim = 2'd3;
         3'd2, 3'd3: lim = 2'd2;
         3'd4, 3'd5, 3'd6: lim = 2'd1;
         default: lim = 2'd0;
      endcase
      return lim;
   endfunction

   function automatic burst_type quantum(input level_type lv);
      return burst_type'(1) << lv;
   endfunction

   function automatic burst_type sat_burst(input logic [REQ_BURST_W-1:0] b);
      logic [63:0] wide;
      logic [63:0] top;
      wide = 64'(b);
      top  = (64'(1) << BURST_BITS) - 64'(1);
      if (wide > top) begin
         return '1;
      end
      return wide[BURST_BITS-1:0];
   endfunction

endpackage

### hw/rtl/mlfq_cell.sv
// One storage cell of a level queue: holds one remaining burst time.
// Depends on mlfq_pkg for the word type.
module mlfq_cell
   import mlfq_pkg::*;
(
   input  logic      clock,
   input  logic      shift_en,
   input  logic      load_en,
   input  burst_type shift_data,
   input  burst_type load_data,
   output burst_type value
);

   burst_type value_ff;
   burst_type value_in;

   always_comb begin
      value_in = value_ff;
      if (load_en) begin
         value_in = load_data;
      end else if (shift_en) begin
         value_in = shift_data;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

### hw/rtl/mlfq_level.sv
// One level queue: a row of mlfq_cell instances that shifts towards the head on
// a pop, plus its fill count. Depends on mlfq_pkg and mlfq_cell.
module mlfq_level
   import mlfq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  level_ctl_type ctl,
   output burst_type     head,
   output count_type     count,
   output logic          full
);

   count_type count_ff;
   count_type count_in;
   burst_type values [DEPTH];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      burst_type nxt;
      logic      load;
      if (i == DEPTH - 1) begin : g_tail
         assign nxt = '0;
      end else begin : g_body
         assign nxt = values[i+1];
      end
      assign load = (ctl.push && count_ff == CNT_W'(i)) || (ctl.set_head && i == 0);
      mlfq_cell u_cell (
         .clock      (clock),
         .shift_en   (ctl.pop),
         .load_en    (load),
         .shift_data (nxt),
         .load_data  (ctl.data),
         .value      (values[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctl.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign head  = values[0];
   assign count = count_ff;
   assign full  = (count_ff == CNT_W'(DEPTH));

endmodule

### hw/rtl/multilevel_feedback_queue.sv
// Multilevel feedback queue scheduler with seven level queues of burst times.
// An enqueue word goes from acceptance to the reply state and then to its result.
// A service pass serves up to three entries in the serve state, then replies:
// each level queue is a row of cells whose head cell is served once a cycle, and a
// new word is taken only once the previous one has left the serve loop. The
// result sits in an output register, so the next word may enter while it waits.
// Depends on mlfq_pkg, mlfq_level and assert_macros.svh.
`include "assert_macros.svh"
module multilevel_feedback_queue
   import mlfq_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [LEVEL_W-1:0]     req_level,
   input  logic [REQ_BURST_W-1:0] req_burst,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_accepted,
   output logic [TALLY_W-1:0]     rsp_finished,
   output logic [TALLY_W-1:0]     rsp_demoted,
   output logic [TALLY_W-1:0]     rsp_dropped
);

   state_type          state_ff, state_in;
   level_type          lv_ff, lv_in;
   logic [SERVE_W-1:0] remaining_ff, remaining_in;
   logic               acc_ff, acc_in;
   logic [TALLY_W-1:0] fin_ff, fin_in, dem_ff, dem_in, drp_ff, drp_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_acc_ff, rsp_acc_in;
   logic [TALLY_W-1:0] rsp_fin_ff, rsp_fin_in;
   logic [TALLY_W-1:0] rsp_dem_ff, rsp_dem_in;
   logic [TALLY_W-1:0] rsp_drp_ff, rsp_drp_in;

   level_ctl_type ctl   [LEVELS];
   burst_type     heads [LEVELS];
   count_type     counts[LEVELS];
   logic          fulls [LEVELS];

   burst_type          head_sel;
   logic               full_next;
   count_type          req_count;
   logic [SERVE_W-1:0] serve_req;
   burst_type          new_burst;
   burst_type          rest;
   logic               rsp_free;

   for (genvar k = 0; k < LEVELS; k++) begin : g_level
      mlfq_level u_level (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl[k]),
         .head  (heads[k]),
         .count (counts[k]),
         .full  (fulls[k])
      );
   end

   always_comb begin
      head_sel  = '0;
      full_next = 1'b1;
      req_count = '0;
      for (int k = 0; k < LEVELS; k++) begin
         if (LEVEL_W'(k) == lv_ff) begin
            head_sel = heads[k];
         end
         if (k > 0 && LEVEL_W'(k - 1) == lv_ff) begin
            full_next = fulls[k];
         end
         if (LEVEL_W'(k) == req_level) begin
            req_count = counts[k];
         end
      end
   end

   assign serve_req = (req_count < CNT_W'(serve_limit(req_level))) ?
                      SERVE_W'(req_count) : serve_limit(req_level);
   assign new_burst = sat_burst(req_burst);
   assign rest      = head_sel - quantum(lv_ff);
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_cmd == CMD_PASS && req_level <= LEVEL_LAST && serve_req != '0) begin
                  state_in = ST_SERVE;
               end else begin
                  state_in = ST_REPLY;
               end
            end
         end
         ST_SERVE: begin
            if (remaining_ff == SERVE_W'(1)) begin
               state_in = ST_REPLY;
            end
         end
         ST_REPLY: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      lv_in        = lv_ff;
      remaining_in = remaining_ff;
      acc_in       = acc_ff;
      fin_in       = fin_ff;
      dem_in       = dem_ff;
      drp_in       = drp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_acc_in   = rsp_acc_ff;
      rsp_fin_in   = rsp_fin_ff;
      rsp_dem_in   = rsp_dem_ff;
      rsp_drp_in   = rsp_drp_ff;
      for (int k = 0; k < LEVELS; k++) begin
         ctl[k] = '{pop: 1'b0, push: 1'b0, set_head: 1'b0, data: '0};
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               lv_in        = req_level;
               fin_in       = '0;
               dem_in       = '0;
               drp_in       = '0;
               remaining_in = '0;
               if (req_cmd == CMD_ENQUEUE) begin
                  acc_in = (new_burst != '0) && !fulls[0];
                  if (acc_in) begin
                     ctl[0].push = 1'b1;
                     ctl[0].data = new_burst;
                  end
               end else begin
                  acc_in       = (req_level <= LEVEL_LAST);
                  remaining_in = acc_in ? serve_req : '0;
               end
            end
         end
         ST_SERVE: begin
            remaining_in = remaining_ff - SERVE_W'(1);
            for (int k = 0; k < LEVELS; k++) begin
               if (LEVEL_W'(k) == lv_ff) begin
                  if (head_sel > quantum(lv_ff)) begin
                     if (k == LAST_LEVEL) begin
                        ctl[k].set_head = 1'b1;
                        ctl[k].data     = rest;
                     end else begin
                        ctl[k].pop = 1'b1;
                        if (!full_next) begin
                           ctl[k+1].push = 1'b1;
                           ctl[k+1].data = rest;
                        end
                     end
                  end else begin
                     ctl[k].pop = 1'b1;
                  end
               end
            end
            if (head_sel <= quantum(lv_ff)) begin
               fin_in = fin_ff + TALLY_W'(1);
            end else if (lv_ff != LEVEL_LAST) begin
               if (full_next) begin
                  drp_in = drp_ff + TALLY_W'(1);
               end else begin
                  dem_in = dem_ff + TALLY_W'(1);
               end
            end
         end
         ST_REPLY: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_acc_in   = acc_ff;
               rsp_fin_in   = fin_ff;
               rsp_dem_in   = dem_ff;
               rsp_drp_in   = drp_ff;
            end
         end
         default: begin
            remaining_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remaining_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      lv_ff      <= lv_in;
      acc_ff     <= acc_in;
      fin_ff     <= fin_in;
      dem_ff     <= dem_in;
      drp_ff     <= drp_in;
      rsp_acc_ff <= rsp_acc_in;
      rsp_fin_ff <= rsp_fin_in;
      rsp_dem_ff <= rsp_dem_in;
      rsp_drp_ff <= rsp_drp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_finished = rsp_fin_ff;
   assign rsp_demoted  = rsp_dem_ff;
   assign rsp_dropped  = rsp_drp_ff;

   `MLFQ_ASSERT(a_serve_has_work, clock, reset, (state_ff == ST_SERVE) |-> (remaining_ff != '0), "Serve state entered with nothing left to serve.")
   `MLFQ_ASSERT(a_tally_bound, clock, reset, rsp_valid_ff |-> ((3'(rsp_fin_ff) + 3'(rsp_dem_ff) + 3'(rsp_drp_ff)) <= 3'd3), "More jobs reported than a pass can serve.")
   `MLFQ_ASSERT(a_reject_quiet, clock, reset, (rsp_valid_ff && !rsp_acc_ff) |-> (rsp_fin_ff == '0 && rsp_dem_ff == '0 && rsp_drp_ff == '0), "Rejected word reports job counts.")
   `MLFQ_NEVER(a_last_no_push, clock, reset, state_ff == ST_SERVE && lv_ff == LEVEL_LAST && ctl[LAST_LEVEL].pop && heads[LAST_LEVEL] > quantum(LEVEL_LAST), "A job with time left was removed from the last level.")

endmodule
